// ===== src/periodic_task_due_scheduler_defines.svh =====
// Assertion macros shared by the scheduler RTL.
// Each check samples on clk and is disabled while rst_n is low.
`ifndef PERIODIC_TASK_DUE_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_DUE_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition holds on every rising clock edge.
`define PTDS_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define PTDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`else

`define PTDS_ASSERT_ALW(lbl, cond, msg)
`define PTDS_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

// ===== src/ptds_pkg.sv =====
`default_nettype none

package ptds_pkg;

  // Input operation codes
  localparam logic [2:0] OP_RUN        = 3'd0;
  localparam logic [2:0] OP_REGISTER   = 3'd1;
  localparam logic [2:0] OP_UNREGISTER = 3'd2;
  localparam logic [2:0] OP_SUSPEND    = 3'd3;
  localparam logic [2:0] OP_RESUME     = 3'd4;

  // Result status codes
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_REJ  = 1'b1;

  // Slot commands broadcast to the cell row
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_ALLOC = 3'd1;
  localparam logic [2:0] CMD_DROP  = 3'd2;
  localparam logic [2:0] CMD_HOLD  = 3'd3;
  localparam logic [2:0] CMD_WAKE  = 3'd4;

  // Control from the sequencer to every cell
  typedef struct packed {
    logic [2:0] cmd;
    logic       adv;
  } cell_ctl_t;

  // Status from one cell back to the sequencer
  typedef struct packed {
    logic tok;
    logic hit;
    logic live;
  } cell_stat_t;

endpackage

`default_nettype wire

// ===== src/ptds_cell.sv =====
`default_nettype none

module ptds_cell import ptds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cell_ctl_t   ctl,
  input  wire logic        sel,
  input  wire logic [31:0] now_ms,
  input  wire logic [31:0] period_ms,
  input  wire logic        tok_in,
  output cell_stat_t       stat
);

  logic [31:0] period_r;
  logic [31:0] last_r;
  logic        en_r;
  logic        live_r;
  logic        tok_r;
  logic [31:0] elapsed;
  logic        due;

  // Compare wrap-around elapsed time against the interval
  assign elapsed = now_ms - last_r;
  assign due     = tok_r && en_r && live_r && (elapsed >= period_r);

  assign stat.tok  = tok_r;
  assign stat.hit  = due;
  assign stat.live = live_r;

  // Advance the scan token to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else if (ctl.adv) begin
      tok_r <= tok_in;
    end
  end

  // Apply slot commands to the enable and live flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r   <= 1'b0;
      live_r <= 1'b0;
    end else if (sel) begin
      unique case (ctl.cmd)
        CMD_ALLOC: begin
          en_r   <= 1'b1;
          live_r <= 1'b1;
        end
        CMD_DROP: begin
          en_r   <= 1'b0;
          live_r <= 1'b0;
        end
        CMD_HOLD: en_r <= 1'b0;
        CMD_WAKE: en_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Hold interval and stamp payload; restamp on alloc, wake or a due hit
  always_ff @(posedge clk) begin
    if (sel && ctl.cmd == CMD_ALLOC) begin
      period_r <= period_ms;
    end
    if ((sel && (ctl.cmd == CMD_ALLOC || ctl.cmd == CMD_WAKE)) || (ctl.adv && due)) begin
      last_r <= now_ms;
    end
  end

endmodule

`default_nettype wire

// ===== src/periodic_task_due_scheduler.sv =====
// Periodic task due scheduler: a row of SLOT_COUNT task slots.
// Input channel (in_valid / in_stall) takes one operation per item: run check,
// register, unregister, suspend or resume. Result channel (out_valid /
// out_stall) returns one or more result items per input item, the final one
// marked by out_last.
// Register, unregister, suspend, resume and rejected codes: one result, shown
// the cycle after the item is accepted; a new item is taken once that result
// is taken or the output register is free.
// Run check: a token walks the cell row, one slot per cycle while no receiver
// stall holds it back. Due results come out in ascending slot order; one due
// slot is held back so that the final one can carry out_last.
// The input is stalled while a run is in progress.
// A receiver stall freezes the walk only when a finished result cannot move;
// no result is dropped or repeated.
// Reset (rst_n low, synchronous) frees every slot and clears all pending work.
`default_nettype none
`include "periodic_task_due_scheduler_defines.svh"

module periodic_task_due_scheduler import ptds_pkg::*; #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [2:0]  in_opcode,
  input  wire logic [7:0]  in_slot_index,
  input  wire logic [31:0] in_period_ms,
  input  wire logic [31:0] in_now_ms,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic        out_status,
  output      logic [5:0]  out_slot_out,
  output      logic        out_due_valid,
  output      logic        out_last
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int UW = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [IW-1:0]         pend_slot_r, pend_slot_nxt;
  logic [UW-1:0]         used_r, used_nxt;
  logic [31:0]           now_r;

  logic                  out_valid_r;
  logic                  out_status_r;
  logic [5:0]            out_slot_r;
  logic                  out_due_r;
  logic                  out_last_r;

  logic                  out_free;
  logic                  in_acc;
  logic                  load_out;
  logic                  ld_status;
  logic [5:0]            ld_slot;
  logic                  ld_due;
  logic                  ld_last;
  logic                  start;
  logic                  adv;
  logic [2:0]            cmd;
  logic                  live_idx;
  logic                  scan_hit;
  logic [31:0]           cell_now;

  cell_ctl_t             ctl;
  cell_stat_t            stat [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] idx_sel;
  logic [SLOT_COUNT-1:0] alloc_sel;
  logic [SLOT_COUNT-1:0] sel_vec;
  logic [SLOT_COUNT-1:0] live_vec;
  logic [SLOT_COUNT-1:0] hit_vec;
  logic [SLOT_COUNT-1:0] tok_vec;
  logic [SLOT_COUNT:0]   tok_chain;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == ST_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;

  // Decode slot selects and gather cell status
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_sel
    assign idx_sel[i]   = (in_slot_index == 8'(i));
    assign alloc_sel[i] = (used_r == UW'(i));
    assign live_vec[i]  = stat[i].live;
    assign hit_vec[i]   = stat[i].hit;
    assign tok_vec[i]   = stat[i].tok;
  end

  assign sel_vec  = (cmd == CMD_ALLOC) ? alloc_sel : idx_sel;
  assign live_idx = |(live_vec & idx_sel);
  assign scan_hit = |hit_vec;
  assign cell_now = (state_r == ST_IDLE) ? in_now_ms : now_r;

  // Sequence operations, scan steps and result loads
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    used_nxt      = used_r;
    load_out      = 1'b0;
    ld_status     = ST_DONE;
    ld_slot       = '0;
    ld_due        = 1'b0;
    ld_last       = 1'b1;
    cmd           = CMD_NONE;
    adv           = 1'b1;
    start         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          unique case (in_opcode)
            OP_RUN: begin
              load_out   = 1'b0;
              start      = 1'b1;
              idx_nxt    = '0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_SCAN;
            end
            OP_REGISTER: begin
              if (in_period_ms != 32'd0 && used_r < UW'(SLOT_COUNT)) begin
                cmd      = CMD_ALLOC;
                used_nxt = used_r + 1'b1;
                ld_slot  = 6'(used_r);
              end else begin
                ld_status = ST_REJ;
              end
            end
            OP_UNREGISTER: begin
              if (in_slot_index < 8'(SLOT_COUNT) && live_idx) begin
                cmd = CMD_DROP;
              end else begin
                ld_status = ST_REJ;
              end
            end
            OP_SUSPEND: begin
              if (in_slot_index < 8'(used_r)) begin
                cmd = CMD_HOLD;
              end else begin
                ld_status = ST_REJ;
              end
            end
            OP_RESUME: begin
              if (in_slot_index < 8'(used_r)) begin
                cmd = CMD_WAKE;
              end else begin
                ld_status = ST_REJ;
              end
            end
            default: ld_status = ST_REJ;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_hit && pend_v_r) begin
          adv = out_free;
          if (out_free) begin
            load_out      = 1'b1;
            ld_slot       = 6'(pend_slot_r);
            ld_due        = 1'b1;
            ld_last       = 1'b0;
            pend_slot_nxt = idx_r;
          end
        end else if (scan_hit) begin
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = idx_r;
        end
        if (adv) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == IW'(SLOT_COUNT - 1)) begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          load_out   = 1'b1;
          ld_due     = pend_v_r;
          ld_slot    = pend_v_r ? 6'(pend_slot_r) : 6'd0;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ctl.cmd = cmd;
  assign ctl.adv = adv;

  // Build the cell row; the token enters at slot zero
  assign tok_chain[0] = start;
  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
    ptds_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .sel       (sel_vec[i]),
      .now_ms    (cell_now),
      .period_ms (in_period_ms),
      .tok_in    (tok_chain[i]),
      .stat      (stat[i])
    );
    assign tok_chain[i+1] = stat[i].tok;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pend_v_r <= 1'b0;
      used_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      pend_v_r <= pend_v_nxt;
      used_r   <= used_nxt;
    end
  end

  // Scan position, held slot and latched tick
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    if (in_acc) begin
      now_r <= in_now_ms;
    end
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= ld_status;
      out_slot_r   <= ld_slot;
      out_due_r    <= ld_due;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot_out  = out_slot_r;
  assign out_due_valid = out_due_r;
  assign out_last      = out_last_r;

  `PTDS_ASSERT_IMP(a_tok_scan, state_r == ST_SCAN, $onehot(tok_vec), "scan token lost or split")
  `PTDS_ASSERT_IMP(a_tok_idle, state_r != ST_SCAN, tok_vec == '0, "stray scan token")
  `PTDS_ASSERT_ALW(a_used_max, used_r <= UW'(SLOT_COUNT), "slot count beyond table")
  `PTDS_ASSERT_IMP(a_pend_idle, state_r == ST_IDLE, !pend_v_r, "held due slot while idle")
  `PTDS_ASSERT_IMP(a_due_run, load_out && ld_due, state_r != ST_IDLE, "due result outside a run")

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import ptds_pkg::*;

  localparam int SLOTS = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SHOWN_MISMATCHES = 10;
  localparam logic [2:0] OP_TOP_CODE = 3'd7;

  typedef struct {
    logic       status;
    logic [5:0] slot;
    logic       due;
    logic       last;
  } sched_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = 3'd0;
  logic [7:0]  in_slot_index = 8'd0;
  logic [31:0] in_period_ms = 32'd0;
  logic [31:0] in_now_ms = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_status;
  logic [5:0]  out_slot_out;
  logic        out_due_valid;
  logic        out_last;

  // Shadow copy of the slot table
  logic [31:0] interval_m[SLOTS];
  logic [31:0] stamp_m[SLOTS];
  logic        en_m[SLOTS];
  logic        live_m[SLOTS];
  int          used_m = 0;

  sched_res_t  owed_results[$];
  logic [31:0] now_tick = 32'd0;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  // Sender and receiver pacing
  int          burst_left = 0;
  bit          steady_sender = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          pat_age = 0;
  logic [15:0] stall_pat = 16'd0;
  logic [3:0]  pat_pos = 4'd0;

  periodic_task_due_scheduler #(.SLOT_COUNT(SLOTS)) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_slot_index(in_slot_index),
    .in_period_ms (in_period_ms),
    .in_now_ms    (in_now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .out_slot_out (out_slot_out),
    .out_due_valid(out_due_valid),
    .out_last     (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one operation to the shadow table and queue the results it owes
  task automatic schedule_step(input logic [2:0] op, input logic [7:0] idx,
                               input logic [31:0] period, input logic [31:0] now);
    sched_res_t due_list[SLOTS];
    sched_res_t r;
    logic [31:0] elapsed;
    int n;
    n = 0;
    r = '{status: ST_REJ, slot: 6'd0, due: 1'b0, last: 1'b1};
    case (op)
      OP_RUN: begin
        r.status = ST_DONE;
        for (int i = 0; i < used_m; i++) begin
          elapsed = now - stamp_m[i];
          if (en_m[i] && live_m[i] && elapsed >= interval_m[i]) begin
            stamp_m[i] = now;
            due_list[n] = '{status: ST_DONE, slot: 6'(i), due: 1'b1, last: 1'b0};
            n++;
          end
        end
      end
      OP_REGISTER: begin
        if (period != 32'd0 && used_m < SLOTS) begin
          interval_m[used_m] = period;
          stamp_m[used_m] = now;
          en_m[used_m] = 1'b1;
          live_m[used_m] = 1'b1;
          r.status = ST_DONE;
          r.slot = 6'(used_m);
          used_m++;
        end
      end
      OP_UNREGISTER: begin
        if (idx < SLOTS && live_m[idx]) begin
          en_m[idx] = 1'b0;
          live_m[idx] = 1'b0;
          r.status = ST_DONE;
        end
      end
      OP_SUSPEND, OP_RESUME: begin
        if (idx < used_m) begin
          if (op == OP_SUSPEND) begin
            en_m[idx] = 1'b0;
          end else begin
            en_m[idx] = 1'b1;
            stamp_m[idx] = now;
          end
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    if (n == 0) begin
      owed_results.push_back(r);
    end else begin
      due_list[n - 1].last = 1'b1;
      for (int k = 0; k < n; k++) owed_results.push_back(due_list[k]);
    end
  endtask

  // Offer one item from a falling edge, hold it until taken, then maybe idle
  task automatic send_item(input logic [2:0] op, input logic [7:0] idx,
                           input logic [31:0] period, input logic [31:0] now);
    int gap;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_slot_index <= idx;
    in_period_ms <= period;
    in_now_ms <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    schedule_step(op, idx, period, now);
    @(negedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (owed_results.size() != 0) @(negedge clk);
  endtask

  // Mostly well-formed traffic over in-range slot indices, with some noise
  task automatic make_item(output logic [2:0] op, output logic [7:0] idx,
                           output logic [31:0] period);
    int pick;
    pick = $urandom_range(0, 99);
    idx = 8'($urandom_range(0, SLOTS - 1));
    period = $urandom;
    if (pick < 52) begin
      op = OP_RUN;
    end else if (pick < 60) begin
      op = OP_REGISTER;
      if ($urandom_range(0, 19) == 0) period = 32'd0;
      else if ($urandom_range(0, 3) == 0) period = $urandom_range(1, 300);
      else period = $urandom_range(1, 30);
    end else if (pick < 70) begin
      op = OP_SUSPEND;
    end else if (pick < 83) begin
      op = OP_RESUME;
    end else if (pick < 85) begin
      op = OP_UNREGISTER;
    end else begin
      op = 3'($urandom_range(0, OP_TOP_CODE));
      idx = 8'($urandom_range(0, 255));
    end
    // advance time in small ticks, with an occasional far jump
    if ($urandom_range(0, 15) == 0) now_tick = now_tick + $urandom;
    else now_tick = now_tick + $urandom_range(0, 24);
  endtask

  task automatic test_empty_table();
    now_tick = 32'hFFFF_FFF0;
    send_item(OP_RUN, 8'd0, 32'd0, now_tick);
    send_item(OP_REGISTER, 8'd0, 32'd0, now_tick);
    send_item(OP_SUSPEND, 8'd0, 32'd5, now_tick);
    send_item(OP_RESUME, 8'd0, 32'd5, now_tick);
    send_item(OP_UNREGISTER, 8'd0, 32'd5, now_tick);
    send_item(OP_UNREGISTER, 8'hFF, 32'd5, now_tick);
    for (int c = OP_RESUME + 1; c <= OP_TOP_CODE; c++) begin
      send_item(3'(c), 8'hFF, 32'hFFFF_FFFF, now_tick);
    end
  endtask

  // Stamps just below the wrap point, runs just after it
  task automatic test_wrap_and_due();
    send_item(OP_REGISTER, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    send_item(OP_REGISTER, 8'd0, 32'd1, 32'hFFFF_FFF0);
    send_item(OP_REGISTER, 8'd0, 32'd16, 32'hFFFF_FFF8);
    send_item(OP_RUN, 8'd0, 32'd0, 32'd0);
    send_item(OP_RUN, 8'd0, 32'd0, 32'd8);
    send_item(OP_RUN, 8'd0, 32'd0, 32'd8);
  endtask

  task automatic test_suspend_resume();
    send_item(OP_SUSPEND, 8'd1, 32'd0, 32'd9);
    send_item(OP_RUN, 8'd0, 32'd0, 32'd20);
    send_item(OP_RESUME, 8'd1, 32'd0, 32'd20);
    send_item(OP_UNREGISTER, 8'd2, 32'd0, 32'd20);
    // a dead slot takes resume but never comes due
    send_item(OP_RESUME, 8'd2, 32'd0, 32'd20);
    send_item(OP_SUSPEND, 8'd3, 32'd0, 32'd20);
    send_item(OP_RESUME, 8'd200, 32'd0, 32'd20);
    send_item(OP_UNREGISTER, 8'd2, 32'd0, 32'd20);
    send_item(OP_RUN, 8'd0, 32'd0, 32'd40);
    now_tick = 32'd40;
  endtask

  task automatic test_random_traffic(input int count, input bit steady);
    logic [2:0]  op;
    logic [7:0]  idx;
    logic [31:0] period;
    steady_sender = steady;
    repeat (count) begin
      make_item(op, idx, period);
      send_item(op, idx, period, now_tick);
    end
    steady_sender = 1'b0;
  endtask

  task automatic test_sender_pause();
    test_random_traffic(30, 1'b0);
    pause_until_drained();
    test_random_traffic(30, 1'b0);
  endtask

  // Hold the output long enough for the block to back up into its input
  task automatic test_stalled_output();
    hold_req = 1'b1;
    test_random_traffic(40, 1'b1);
  endtask

  // Receiver: long hold on request, otherwise a rotating stall pattern
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (pat_age == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
        pat_age = $urandom_range(16, 96);
      end
      pat_age--;
      out_stall <= stall_pat[pat_pos];
      pat_pos = pat_pos + 4'd1;
    end
  end

  // Compare each taken result with the oldest owed one
  always @(posedge clk) begin : check_results
    sched_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_MISMATCHES) begin
          $display("unexpected result: status=%0d slot=%0d due=%0d last=%0d",
                   out_status, out_slot_out, out_due_valid, out_last);
        end
      end else begin
        want = owed_results.pop_front();
        if (out_status !== want.status || out_slot_out !== want.slot ||
            out_due_valid !== want.due || out_last !== want.last) begin
          fail_count++;
          if (fail_count <= SHOWN_MISMATCHES) begin
            $display("result mismatch: expected status=%0d slot=%0d due=%0d last=%0d",
                     want.status, want.slot, want.due, want.last);
            $display("                 got      status=%0d slot=%0d due=%0d last=%0d",
                     out_status, out_slot_out, out_due_valid, out_last);
          end
        end
      end
    end
  end

  // Stop a hung run: too many cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      interval_m[i] = 32'd0;
      stamp_m[i] = 32'd0;
      en_m[i] = 1'b0;
      live_m[i] = 1'b0;
    end
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_wrap_and_due();
    test_suspend_resume();
    test_random_traffic(130, 1'b0);
    test_sender_pause();
    test_stalled_output();
    test_random_traffic(110, 1'b1);

    // Let the last run finish its walk before judging
    pause_until_drained();
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
